// ===== src/lpfd_pkg.sv =====
// Package for the length-prefixed frame deframer.
// Holds item types, result and error codes, register indexes and fixed widths.
// No dependencies.
package lpfd_pkg;

  localparam int unsigned ByteW       = 8;
  localparam int unsigned PayloadLenW = 24;
  localparam int unsigned CfgIndexW   = 2;
  localparam int unsigned CfgDataW    = 24;
  localparam int unsigned LenFieldW   = 32;

  localparam logic [LenFieldW-1:0] HeaderExtra = 32'd3;
  localparam logic [1:0]           LenLastIdx  = 2'd3;

  localparam logic [1:0] KindHeader  = 2'd0;
  localparam logic [1:0] KindPayload = 2'd1;
  localparam logic [1:0] KindError   = 2'd2;

  localparam logic [1:0] ErrShortLength   = 2'd0;
  localparam logic [1:0] ErrOversized     = 2'd1;
  localparam logic [1:0] ErrUnknownChannel = 2'd2;

  localparam logic [CfgIndexW-1:0] CfgControlCode = 2'd0;
  localparam logic [CfgIndexW-1:0] CfgVideoCode   = 2'd1;
  localparam logic [CfgIndexW-1:0] CfgMaxPayload  = 2'd2;

  localparam logic [ByteW-1:0]       ResetControlCode = 8'd0;
  localparam logic [ByteW-1:0]       ResetVideoCode   = 8'd1;
  localparam logic [CfgDataW-1:0]    ResetMaxPayload  = 24'hFFFFFF;

  typedef enum logic [4:0] {
    PhLength  = 5'b00001,
    PhChannel = 5'b00010,
    PhType    = 5'b00100,
    PhFlags   = 5'b01000,
    PhPayload = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] stream_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]             result_kind;
    logic [ByteW-1:0]       channel_id;
    logic [ByteW-1:0]       message_type;
    logic [ByteW-1:0]       frame_flags;
    logic [PayloadLenW-1:0] payload_length;
    logic [ByteW-1:0]       payload_byte;
    logic                   last_of_frame;
    logic [1:0]             error_code;
  } out_item_t;

  typedef struct packed {
    logic halted;
    logic in_payload;
  } parse_status_t;

endpackage

// ===== src/lpfd_stream_if.sv =====
// Valid/ready item channel for the frame deframer.
// Payload type is a parameter; depends on nothing else.
interface lpfd_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/lpfd_in_stage.sv =====
// Input register of the frame deframer: holds one accepted stream byte.
// Depends on lpfd_pkg.
module lpfd_in_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [lpfd_pkg::ByteW-1:0] byte_i,
  output logic                   ready_o,
  input  logic                   advance_i,
  output logic                   valid_o,
  output logic [lpfd_pkg::ByteW-1:0] byte_o
);

  logic                       valid_q;
  logic [lpfd_pkg::ByteW-1:0] byte_q;

  assign ready_o = !valid_q || advance_i;
  assign valid_o = valid_q;
  assign byte_o  = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (valid_i && ready_o) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      byte_q <= byte_i;
    end
  end

endmodule

// ===== src/lpfd_parser.sv =====
// Frame parser: configuration registers, frame phase state and result logic.
// Depends on lpfd_pkg.
module lpfd_parser #(
  parameter int unsigned PAYLOAD_COUNT_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                advance_i,
  input  logic [lpfd_pkg::ByteW-1:0]          byte_i,
  input  logic                                cfg_we_i,
  input  logic [lpfd_pkg::CfgIndexW-1:0]      cfg_index_i,
  input  logic [lpfd_pkg::CfgDataW-1:0]       cfg_data_i,
  output logic                                res_valid_o,
  output lpfd_pkg::out_item_t                 res_o,
  output lpfd_pkg::parse_status_t             status_o
);

  localparam logic [32:0] CountMask = (33'd1 << PAYLOAD_COUNT_BITS) - 33'd1;

  logic [lpfd_pkg::ByteW-1:0]    ctrl_code_q, video_code_q;
  logic [lpfd_pkg::CfgDataW-1:0] max_payload_q;

  lpfd_pkg::phase_e              phase_q, phase_d;
  logic [1:0]                    idx_q, idx_d;
  logic [23:0]                   accum_q, accum_d;
  logic [PAYLOAD_COUNT_BITS-1:0] left_q, left_d;
  logic [PAYLOAD_COUNT_BITS-1:0] held_len_q, held_len_d;
  logic [lpfd_pkg::ByteW-1:0]    held_ch_q, held_ch_d;
  logic [lpfd_pkg::ByteW-1:0]    held_type_q, held_type_d;
  logic [lpfd_pkg::ByteW-1:0]    held_flags_q;
  logic                          halted_q, halted_d;

  logic [lpfd_pkg::LenFieldW-1:0] frame_len, pay_len;
  logic [32:0]                    limit;
  logic [PAYLOAD_COUNT_BITS-1:0]  left_dec;
  logic                           hdr_err;
  logic [1:0]                     err_code;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_code_q   <= lpfd_pkg::ResetControlCode;
      video_code_q  <= lpfd_pkg::ResetVideoCode;
      max_payload_q <= lpfd_pkg::ResetMaxPayload;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lpfd_pkg::CfgControlCode: ctrl_code_q   <= cfg_data_i[lpfd_pkg::ByteW-1:0];
        lpfd_pkg::CfgVideoCode:   video_code_q  <= cfg_data_i[lpfd_pkg::ByteW-1:0];
        lpfd_pkg::CfgMaxPayload:  max_payload_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign frame_len = {byte_i, accum_q};
  assign pay_len   = frame_len - lpfd_pkg::HeaderExtra;
  assign limit     = (33'(max_payload_q) > CountMask) ? CountMask : 33'(max_payload_q);
  assign left_dec  = (left_q != '0) ? left_q - 1'b1 : left_q;

  always_comb begin
    phase_d     = phase_q;
    idx_d       = idx_q;
    accum_d     = accum_q;
    left_d      = left_q;
    held_len_d  = held_len_q;
    held_ch_d   = held_ch_q;
    held_type_d = held_type_q;
    halted_d    = halted_q;
    hdr_err     = 1'b0;
    err_code    = lpfd_pkg::ErrShortLength;
    res_valid_o = 1'b0;
    res_o                = '0;
    res_o.channel_id     = held_ch_q;
    res_o.message_type   = held_type_q;
    res_o.payload_length = lpfd_pkg::PayloadLenW'(held_len_q);

    if (advance_i && !halted_q) begin
      unique case (phase_q)
        lpfd_pkg::PhLength: begin
          if (idx_q != lpfd_pkg::LenLastIdx) begin
            unique case (idx_q)
              2'd0:    accum_d[7:0]   = byte_i;
              2'd1:    accum_d[15:8]  = byte_i;
              default: accum_d[23:16] = byte_i;
            endcase
            idx_d = idx_q + 2'd1;
          end else begin
            idx_d   = '0;
            accum_d = '0;
            if (frame_len < lpfd_pkg::HeaderExtra) begin
              hdr_err  = 1'b1;
              err_code = lpfd_pkg::ErrShortLength;
            end else if (33'(pay_len) > limit) begin
              hdr_err  = 1'b1;
              err_code = lpfd_pkg::ErrOversized;
            end else begin
              held_len_d = PAYLOAD_COUNT_BITS'(pay_len);
              phase_d    = lpfd_pkg::PhChannel;
            end
          end
        end
        lpfd_pkg::PhChannel: begin
          if (byte_i != ctrl_code_q && byte_i != video_code_q) begin
            hdr_err  = 1'b1;
            err_code = lpfd_pkg::ErrUnknownChannel;
          end else begin
            held_ch_d = byte_i;
            phase_d   = lpfd_pkg::PhType;
          end
        end
        lpfd_pkg::PhType: begin
          held_type_d = byte_i;
          phase_d     = lpfd_pkg::PhFlags;
        end
        lpfd_pkg::PhFlags: begin
          left_d              = held_len_q;
          res_valid_o         = 1'b1;
          res_o.result_kind   = lpfd_pkg::KindHeader;
          res_o.frame_flags   = byte_i;
          res_o.last_of_frame = (held_len_q == '0);
          phase_d = (held_len_q == '0) ? lpfd_pkg::PhLength : lpfd_pkg::PhPayload;
        end
        lpfd_pkg::PhPayload: begin
          left_d              = left_dec;
          res_valid_o         = 1'b1;
          res_o.result_kind   = lpfd_pkg::KindPayload;
          res_o.frame_flags   = held_flags_q;
          res_o.payload_byte  = byte_i;
          res_o.last_of_frame = (left_dec == '0);
          if (left_dec == '0) begin
            phase_d = lpfd_pkg::PhLength;
          end
        end
        default: begin
          phase_d = lpfd_pkg::PhLength;
          idx_d   = '0;
          accum_d = '0;
        end
      endcase

      if (hdr_err) begin
        halted_d    = 1'b1;
        res_valid_o = 1'b1;
        res_o       = '0;
        res_o.result_kind = lpfd_pkg::KindError;
        res_o.error_code  = err_code;
      end
    end
  end

  // hold the flags byte alongside the other header fields for payload items
  always_ff @(posedge clk_i) begin
    if (advance_i && !halted_q && phase_q == lpfd_pkg::PhFlags) begin
      held_flags_q <= byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= lpfd_pkg::PhLength;
      idx_q    <= '0;
      accum_q  <= '0;
      halted_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      idx_q    <= idx_d;
      accum_q  <= accum_d;
      halted_q <= halted_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q      <= left_d;
    held_len_q  <= held_len_d;
    held_ch_q   <= held_ch_d;
    held_type_q <= held_type_d;
  end

  assign status_o.halted     = halted_q;
  assign status_o.in_payload = (phase_q == lpfd_pkg::PhPayload);

endmodule

// ===== src/lpfd_out_stage.sv =====
// Result register of the frame deframer: holds one result item for the sink.
// Depends on lpfd_pkg.
module lpfd_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  lpfd_pkg::out_item_t item_i,
  output logic                space_o,
  output logic                valid_o,
  output lpfd_pkg::out_item_t item_o,
  input  logic                ready_i
);

  logic                valid_q;
  lpfd_pkg::out_item_t item_q;

  assign space_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

endmodule

// ===== src/length_prefixed_frame_deframer_core.sv =====
// Length-prefixed frame deframer, top level.
// An accepted byte passes through the input register and then the result register on the way to its result item.
// Throughput: one byte per cycle; only a full result register not taken stalls the input.
// Reset: asynchronous, active low; clears frame state and halt, loads register defaults.
// Depends on lpfd_pkg, lpfd_stream_if, lpfd_in_stage, lpfd_parser, lpfd_out_stage.
module length_prefixed_frame_deframer_core #(
  parameter int unsigned PAYLOAD_COUNT_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  lpfd_stream_if.sink                       stream_i,
  lpfd_stream_if.source                     result_o,
  input  logic                              cfg_we_i,
  input  logic [lpfd_pkg::CfgIndexW-1:0]    cfg_index_i,
  input  logic [lpfd_pkg::CfgDataW-1:0]     cfg_data_i
);

  logic                       in_valid;
  logic [lpfd_pkg::ByteW-1:0] in_byte;
  logic                       out_space;
  logic                       advance;
  logic                       res_valid;
  lpfd_pkg::out_item_t        res;
  lpfd_pkg::out_item_t        out_item;
  lpfd_pkg::parse_status_t    status;

  assign advance = in_valid && out_space;

  lpfd_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (stream_i.valid),
    .byte_i    (stream_i.data.stream_byte),
    .ready_o   (stream_i.ready),
    .advance_i (advance),
    .valid_o   (in_valid),
    .byte_o    (in_byte)
  );

  lpfd_parser #(
    .PAYLOAD_COUNT_BITS (PAYLOAD_COUNT_BITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .byte_i      (in_byte),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .status_o    (status)
  );

  lpfd_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .item_i  (res),
    .space_o (out_space),
    .valid_o (result_o.valid),
    .item_o  (out_item),
    .ready_i (result_o.ready)
  );

  assign result_o.data = out_item;

`ifndef SYNTHESIS
  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.halted |-> !res_valid)
    else $error("result produced after error halt");

  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.result_kind == lpfd_pkg::KindError) |->
      (!res.last_of_frame && res.payload_length == '0 && res.channel_id == '0))
    else $error("error result carries frame fields");

  a_payload_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.result_kind == lpfd_pkg::KindPayload) |-> status.in_payload)
    else $error("payload result outside payload phase");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stream_i.ready |-> (result_o.valid && !result_o.ready))
    else $error("input stalled without a blocked result");
`endif

endmodule
